// ===== rtl/core/rsvm_pkg.sv =====
// Shared constants, codes and types of the resampling voice mixer.
`timescale 1ns / 1ps
package rsvm_pkg;

  localparam int FIFO_FRAMES = 256;
  localparam int PTR_W       = (FIFO_FRAMES > 1) ? $clog2(FIFO_FRAMES) : 1;
  localparam int CNT_W       = $clog2(FIFO_FRAMES + 1);
  localparam int PHASE_W     = 18;
  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int ALU_W       = PHASE_W + 2;

  localparam int IN_TDATA_W  = 4 * SAMPLE_W;
  localparam int OUT_TDATA_W = ((FRAME_W + CNT_W + 7) / 8) * 8;

  localparam logic [PHASE_W-1:0] PHASE_STEP  = PHASE_W'(44100);
  localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;
  localparam logic [PHASE_W-1:0] RATE_RESET  = PHASE_W'(44100);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  localparam logic CFG_SOURCE_RATE   = 1'b0;
  localparam logic CFG_STEREO_SOURCE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_MIXED    = 3'd2,
    ST_UNDERRUN = 3'd3,
    ST_FINISHED = 3'd4,
    ST_STARTED  = 3'd5
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ===== rtl/core/rsvm_alu.sv =====
// Shared adder with phase compare, phase saturation and 16-bit sample saturation.
`timescale 1ns / 1ps
module rsvm_alu (
  input  rsvm_pkg::alu_op_t                    op,
  input  logic [rsvm_pkg::ALU_W-1:0]           a,
  input  logic [rsvm_pkg::ALU_W-1:0]           b,
  output logic [rsvm_pkg::ALU_W-1:0]           sum,
  output logic                                 ge,
  output logic [rsvm_pkg::SAMPLE_W-1:0]        sat_sample,
  output logic [rsvm_pkg::PHASE_W-1:0]         sat_phase
);
  import rsvm_pkg::*;

  localparam int HI_W = ALU_W - SAMPLE_W + 1;

  logic [ALU_W-1:0] b_eff;
  logic [HI_W-1:0]  hi_bits;

  assign b_eff   = (op == ALU_SUB) ? ~b : b;
  assign sum     = a + b_eff + ALU_W'(op == ALU_SUB);
  assign ge      = ~sum[ALU_W-1];
  assign hi_bits = sum[ALU_W-1:SAMPLE_W-1];

  always_comb begin
    if ((hi_bits == '0) || (hi_bits == '1)) begin
      sat_sample = sum[SAMPLE_W-1:0];
    end else if (sum[ALU_W-1]) begin
      sat_sample = SAMPLE_MIN;
    end else begin
      sat_sample = SAMPLE_MAX;
    end
  end

  assign sat_phase = (sum[ALU_W-1:PHASE_W] != '0) ? PHASE_MAX : sum[PHASE_W-1:0];

endmodule

// ===== rtl/core/resampling_saturating_voice_mixer_top.sv =====
// Top level of one resampling, saturating voice of a stereo mixer.
//
// Input stream (s_*): each transfer is one command. s_tuser carries the function
// (push frame, output tick, start voice), s_tlast marks the final frame of a sound,
// s_tdata carries the source samples and the mix so far. Output stream (m_*): one
// result per command, status in m_tuser, saturated mix and FIFO level in m_tdata.
// Config port (cfg_*): index 0 source rate in Hz, index 1 stereo source flag;
// ready outside reset; the user must write it only while the voice is idle.
// The block does not enforce it. Push, start and unused commands execute, then
// stage the result. A tick pops P (0 to 5) frames, one frame store read per cycle,
// then one shared adder is used for left mix, right mix and phase.
// The next command is taken in the cycle after the result is staged.
// Reset empties the FIFO, sets phase to 44100, stops the voice and sets the
// source rate to 44100 stereo; the frame store itself is not cleared.
// A stalled receiver holds the result in the output register; one further
// command is processed and waits until that register drains.
`timescale 1ns / 1ps
module resampling_saturating_voice_mixer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_left, sample_right, mix_left, mix_right
  input  logic [rsvm_pkg::IN_TDATA_W-1:0]      s_tdata,
  // func
  input  logic [1:0]                           s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_left, out_right, fifo_level, zero pad
  output logic [rsvm_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // status
  output logic [2:0]                           m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [rsvm_pkg::PHASE_W-1:0]         cfg_data
);
  import rsvm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_MIX_L = 7'b0001000,
    S_MIX_R = 7'b0010000,
    S_PHASE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(FIFO_FRAMES - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t                state;
  func_t                 in_func;
  logic [SAMPLE_W-1:0]   in_left;
  logic [SAMPLE_W-1:0]   in_right;
  logic                  in_last;
  logic [SAMPLE_W-1:0]   in_mix_l;
  logic [SAMPLE_W-1:0]   in_mix_r;

  logic [PHASE_W-1:0]    source_rate;
  logic                  stereo_source;

  logic [FRAME_W-1:0]    mem [FIFO_FRAMES];
  logic [FRAME_W-1:0]    rd_data;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W-1:0]      wr_ptr;
  logic [CNT_W-1:0]      frame_count;
  logic [PHASE_W-1:0]    phase;
  logic [FRAME_W-1:0]    held_frame;
  logic                  end_pending;
  logic                  voice_active;
  logic                  pop_pending;

  status_t               res_status;
  logic [SAMPLE_W-1:0]   res_l;
  logic [SAMPLE_W-1:0]   res_r;

  alu_op_t               alu_op;
  logic [ALU_W-1:0]      alu_a;
  logic [ALU_W-1:0]      alu_b;
  logic [ALU_W-1:0]      alu_sum;
  logic                  alu_ge;
  logic [SAMPLE_W-1:0]   alu_sat_sample;
  logic [PHASE_W-1:0]    alu_sat_phase;

  logic                  fifo_full;
  logic                  fifo_empty;
  logic                  push_we;
  logic                  pop;
  logic [SAMPLE_W-1:0]   held_l;
  logic [SAMPLE_W-1:0]   held_r;

  assign s_tready   = (state == S_IDLE) && !rst;
  assign cfg_ready  = !rst;
  assign fifo_full  = (frame_count == CNT_W'(FIFO_FRAMES));
  assign fifo_empty = (frame_count == '0);
  assign push_we    = (state == S_EXEC) && (in_func == FUNC_PUSH) && !fifo_full;
  assign pop        = (state == S_CHECK) && alu_ge && !fifo_empty;
  assign held_l     = held_frame[SAMPLE_W-1:0];
  assign held_r     = stereo_source ? held_frame[FRAME_W-1:SAMPLE_W] : held_l;

  always_comb begin
    unique case (state)
      S_CHECK: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(phase);
        alu_b  = ALU_W'(PHASE_STEP);
      end
      S_MIX_L: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(signed'(in_mix_l));
        alu_b  = ALU_W'(signed'(held_l));
      end
      S_MIX_R: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(signed'(in_mix_r));
        alu_b  = ALU_W'(signed'(held_r));
      end
      S_PHASE: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(phase);
        alu_b  = ALU_W'(source_rate);
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  rsvm_alu u_alu (
    .op         (alu_op),
    .a          (alu_a),
    .b          (alu_b),
    .sum        (alu_sum),
    .ge         (alu_ge),
    .sat_sample (alu_sat_sample),
    .sat_phase  (alu_sat_phase)
  );

  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[wr_ptr] <= {in_right, in_left};
    end
    if (pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      source_rate   <= RATE_RESET;
      stereo_source <= 1'b1;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      frame_count   <= '0;
      phase         <= PHASE_STEP;
      held_frame    <= '0;
      end_pending   <= 1'b0;
      voice_active  <= 1'b0;
      pop_pending   <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_SOURCE_RATE) begin
          source_rate <= cfg_data;
        end else begin
          stereo_source <= cfg_data[0];
        end
      end

      pop_pending <= 1'b0;
      if (pop_pending) begin
        held_frame <= rd_data;
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_func  <= func_t'(s_tuser);
            in_left  <= s_tdata[SAMPLE_W-1:0];
            in_right <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            in_mix_l <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            in_mix_r <= s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
            in_last  <= s_tlast;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_l <= '0;
          res_r <= '0;
          state <= S_DONE;
          unique case (in_func)
            FUNC_PUSH: begin
              if (fifo_full) begin
                res_status <= ST_DROPPED;
              end else begin
                wr_ptr      <= next_ptr(wr_ptr);
                frame_count <= frame_count + 1'b1;
                if (in_last) begin
                  end_pending <= 1'b1;
                end
                res_status <= ST_STORED;
              end
            end
            FUNC_TICK: begin
              res_l <= in_mix_l;
              res_r <= in_mix_r;
              if (!voice_active) begin
                res_status <= ST_FINISHED;
              end else begin
                state <= S_CHECK;
              end
            end
            FUNC_START: begin
              voice_active <= 1'b1;
              phase        <= PHASE_STEP;
              held_frame   <= '0;
              res_status   <= ST_STARTED;
            end
            default: begin
              res_status <= ST_DROPPED;
            end
          endcase
        end
        S_CHECK: begin
          if (alu_ge) begin
            if (fifo_empty) begin
              if (end_pending) begin
                voice_active <= 1'b0;
                end_pending  <= 1'b0;
                res_status   <= ST_FINISHED;
              end else begin
                res_status <= ST_UNDERRUN;
              end
              state <= S_DONE;
            end else begin
              rd_ptr      <= next_ptr(rd_ptr);
              frame_count <= frame_count - 1'b1;
              phase       <= alu_sum[PHASE_W-1:0];
              pop_pending <= 1'b1;
            end
          end else begin
            state <= S_MIX_L;
          end
        end
        S_MIX_L: begin
          res_l <= alu_sat_sample;
          state <= S_MIX_R;
        end
        S_MIX_R: begin
          res_r <= alu_sat_sample;
          state <= S_PHASE;
        end
        S_PHASE: begin
          phase      <= alu_sat_phase;
          res_status <= ST_MIXED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'({frame_count, res_r, res_l});
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_W'(FIFO_FRAMES))
    else $error("frame count above FIFO depth");

  a_phase_below_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX_L) |-> (phase < PHASE_STEP))
    else $error("mix started with phase at or above one step");

  a_mixed_needs_voice: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_MIXED) |-> voice_active)
    else $error("mixed result on an inactive voice");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && alu_ge && !fifo_empty) |=>
      (frame_count == $past(frame_count) - 1'b1))
    else $error("pop did not consume a frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= 3'(ST_STARTED)))
    else $error("result status out of range");

endmodule
